// File: hw/rtl/fbm_pkg.sv
// ----------------------------------------------------------------------------
// fbm_pkg: shared types and codes for the frequency box mask filter
// Register indexes, mode and view codes, gain format, stage control struct.
// ----------------------------------------------------------------------------
package fbm_pkg;

  // gain format: signed Q1.14
  localparam int GAIN_W    = 15;
  localparam int FRAC_BITS = 14;
  localparam int LOG2_W    = 4;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_X_EDGES     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Y_EDGES     = 3'd6;

  // filter modes
  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_BOX       = 3'd1;
  localparam logic [2:0] MODE_BOX_INV   = 3'd2;
  localparam logic [2:0] MODE_BAND      = 3'd3;
  localparam logic [2:0] MODE_BAND_INV  = 3'd4;

  // view modes
  localparam logic [1:0] VIEW_BOTH = 2'd0;
  localparam logic [1:0] VIEW_REAL = 2'd1;
  localparam logic [1:0] VIEW_IMAG = 2'd2;

  localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd8;

  // per-item decision carried down the pipe
  typedef struct packed {
    logic pass;
    logic scl_re;
    logic scl_im;
  } ctl_t;

endpackage

// File: hw/rtl/fbm_region.sv
// ----------------------------------------------------------------------------
// fbm_region: stage 1, coordinate shift and box test
// Applies the wrapped half-grid shift, tests inner and outer boxes and
// resolves the pass decision and which parts get the stop gain.
// ----------------------------------------------------------------------------
module fbm_region #(
  parameter int COORD_BITS  = 12,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic [COORD_BITS-1:0]        column,
  input  logic [COORD_BITS-1:0]        row,
  input  logic signed [SAMPLE_BITS-1:0] re_in,
  input  logic signed [SAMPLE_BITS-1:0] im_in,
  input  logic [2:0]                   filter_mode,
  input  logic [1:0]                   view_mode,
  input  logic [fbm_pkg::LOG2_W-1:0]   width_log2,
  input  logic [fbm_pkg::LOG2_W-1:0]   height_log2,
  input  logic [4*COORD_BITS-1:0]      x_edges,
  input  logic [4*COORD_BITS-1:0]      y_edges,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [SAMPLE_BITS-1:0] re_out,
  output logic signed [SAMPLE_BITS-1:0] im_out,
  output fbm_pkg::ctl_t                ctl_out
);

  localparam int LW = fbm_pkg::LOG2_W + 1;
  localparam logic [LW-1:0] CB = LW'(COORD_BITS);

  logic                          valid_r;
  logic signed [SAMPLE_BITS-1:0] re_r, im_r;
  fbm_pkg::ctl_t                 ctl_r, ctl_nxt;
  logic [LW-1:0]                 wl, hl;
  logic [COORD_BITS-1:0]         xs, ys;
  logic                          inner, outer;

  function automatic logic [LW-1:0] clamp_lg(input logic [fbm_pkg::LOG2_W-1:0] v);
    logic [LW-1:0] e;
    e = {1'b0, v};
    if (e == '0)     return LW'(1);
    else if (e > CB) return CB;
    else             return e;
  endfunction

  function automatic logic [COORD_BITS-1:0] shift_c(input logic [COORD_BITS-1:0] c,
                                                    input logic [LW-1:0] lg);
    logic [COORD_BITS-1:0] mask, half;
    mask = ~({COORD_BITS{1'b1}} << lg);
    half = {{(COORD_BITS-1){1'b0}}, 1'b1} << (lg - LW'(1));
    return (c + half) & mask;
  endfunction

  // lower edge exclusive, upper edge inclusive
  function automatic logic span(input logic [COORD_BITS-1:0] c,
                                input logic [4*COORD_BITS-1:0] e, input int slot);
    logic [COORD_BITS-1:0] lo, hi;
    lo = e[slot*COORD_BITS +: COORD_BITS];
    hi = e[(slot+1)*COORD_BITS +: COORD_BITS];
    return (c > lo) && (c <= hi);
  endfunction

  always_comb begin
    wl    = clamp_lg(width_log2);
    hl    = clamp_lg(height_log2);
    xs    = shift_c(column, wl);
    ys    = shift_c(row, hl);
    inner = span(xs, x_edges, 0) && span(ys, y_edges, 0);
    outer = span(xs, x_edges, 2) && span(ys, y_edges, 2);
    case (filter_mode)
      fbm_pkg::MODE_BOX:      ctl_nxt.pass = inner;
      fbm_pkg::MODE_BOX_INV:  ctl_nxt.pass = !inner;
      fbm_pkg::MODE_BAND:     ctl_nxt.pass = outer && !inner;
      fbm_pkg::MODE_BAND_INV: ctl_nxt.pass = !outer || inner;
      default:                ctl_nxt.pass = 1'b1;
    endcase
    ctl_nxt.scl_re = !ctl_nxt.pass && (view_mode != fbm_pkg::VIEW_IMAG);
    ctl_nxt.scl_im = !ctl_nxt.pass && (view_mode != fbm_pkg::VIEW_REAL);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      re_r  <= re_in;
      im_r  <= im_in;
      ctl_r <= ctl_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign re_out   = re_r;
  assign im_out   = im_r;
  assign ctl_out  = ctl_r;

endmodule

// File: hw/rtl/fbm_mult.sv
// ----------------------------------------------------------------------------
// fbm_mult: stage 2, stop gain products
// Multiplies both parts by the signed Q1.14 stop gain; originals ride along.
// ----------------------------------------------------------------------------
module fbm_mult #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [SAMPLE_BITS-1:0] re_in,
  input  logic signed [SAMPLE_BITS-1:0] im_in,
  input  fbm_pkg::ctl_t                 ctl_in,
  input  logic signed [fbm_pkg::GAIN_W-1:0] stop_gain,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic signed [SAMPLE_BITS-1:0] re_out,
  output logic signed [SAMPLE_BITS-1:0] im_out,
  output logic signed [SAMPLE_BITS+fbm_pkg::GAIN_W-1:0] re_prod,
  output logic signed [SAMPLE_BITS+fbm_pkg::GAIN_W-1:0] im_prod,
  output fbm_pkg::ctl_t                 ctl_out
);

  localparam int PW = SAMPLE_BITS + fbm_pkg::GAIN_W;

  logic                          valid_r;
  logic signed [SAMPLE_BITS-1:0] re_r, im_r;
  logic signed [PW-1:0]          rp_r, ip_r;
  fbm_pkg::ctl_t                 ctl_r;

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      re_r  <= re_in;
      im_r  <= im_in;
      rp_r  <= PW'(re_in) * PW'(stop_gain);
      ip_r  <= PW'(im_in) * PW'(stop_gain);
      ctl_r <= ctl_in;
    end
  end

  assign dn_valid = valid_r;
  assign re_out   = re_r;
  assign im_out   = im_r;
  assign re_prod  = rp_r;
  assign im_prod  = ip_r;
  assign ctl_out  = ctl_r;

endmodule

// File: hw/rtl/fbm_round.sv
// ----------------------------------------------------------------------------
// fbm_round: stage 3, round, saturate and select
// Rounds products half up, saturates to the sample range and picks the
// scaled or original part. Its registers are the output register.
// ----------------------------------------------------------------------------
module fbm_round #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [SAMPLE_BITS-1:0] re_in,
  input  logic signed [SAMPLE_BITS-1:0] im_in,
  input  logic signed [SAMPLE_BITS+fbm_pkg::GAIN_W-1:0] re_prod,
  input  logic signed [SAMPLE_BITS+fbm_pkg::GAIN_W-1:0] im_prod,
  input  fbm_pkg::ctl_t                 ctl_in,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic signed [SAMPLE_BITS-1:0] re_out,
  output logic signed [SAMPLE_BITS-1:0] im_out,
  output logic                          passed
);

  localparam int PW = SAMPLE_BITS + fbm_pkg::GAIN_W;
  localparam int FB = fbm_pkg::FRAC_BITS;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FB - 1);

  logic                          valid_r, pass_r;
  logic signed [SAMPLE_BITS-1:0] re_r, im_r, re_sat, im_sat;

  function automatic logic signed [SAMPLE_BITS-1:0] rnd_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0]        s;
    logic signed [SAMPLE_BITS:0] r;
    s = (p + HALF) >>> FB;
    r = s[SAMPLE_BITS:0];
    if (r[SAMPLE_BITS] == r[SAMPLE_BITS-1]) return r[SAMPLE_BITS-1:0];
    else if (r[SAMPLE_BITS])                return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    else                                    return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  endfunction

  assign re_sat   = rnd_sat(re_prod);
  assign im_sat   = rnd_sat(im_prod);
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      re_r   <= ctl_in.scl_re ? re_sat : re_in;
      im_r   <= ctl_in.scl_im ? im_sat : im_in;
      pass_r <= ctl_in.pass;
    end
  end

  assign dn_valid = valid_r;
  assign re_out   = re_r;
  assign im_out   = im_r;
  assign passed   = pass_r;

endmodule

// File: hw/rtl/frequency_box_mask_filter_top.sv
// ----------------------------------------------------------------------------
// frequency_box_mask_filter_top: 2-D Fourier bin box mask filter
// Config registers, three-stage pipe (box test, multiply, round/saturate).
// ----------------------------------------------------------------------------
// Takes one bin per cycle while in_tready is high and returns one
// filtered bin per input. The three register stages (shift and box test,
// stop gain multiply, round/saturate/select) each hold one item; a stalled
// output backs up stage by stage, so in_tready falls only when all stages
// are full. Configuration must be written while no bins are in flight.
module frequency_box_mask_filter_top #(
  parameter int COORD_BITS  = 12,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // column, row, real_in, imag_in, zero pad
  input  logic [((2*COORD_BITS + 2*SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // real_out, imag_out, zero pad
  output logic [((2*SAMPLE_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  // passed
  output logic [0:0]           out_tuser,
  input  logic                 cfg_wr_en,
  input  logic [fbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [((4*COORD_BITS > fbm_pkg::GAIN_W) ? 4*COORD_BITS
                 : fbm_pkg::GAIN_W) - 1:0] cfg_wdata
);

  localparam int OUT_W    = ((2*SAMPLE_BITS + 7) / 8) * 8;
  localparam int EDGE_W   = 4*COORD_BITS;
  localparam int PW       = SAMPLE_BITS + fbm_pkg::GAIN_W;
  localparam int S        = SAMPLE_BITS;
  localparam int C        = COORD_BITS;

  logic [2:0]                        filter_mode_r;
  logic [1:0]                        view_mode_r;
  logic signed [fbm_pkg::GAIN_W-1:0] stop_gain_r;
  logic [fbm_pkg::LOG2_W-1:0]        width_log2_r, height_log2_r;
  logic [EDGE_W-1:0]                 x_edges_r, y_edges_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r <= fbm_pkg::MODE_NONE;
      view_mode_r   <= fbm_pkg::VIEW_BOTH;
      stop_gain_r   <= '0;
      width_log2_r  <= fbm_pkg::LOG2_RESET;
      height_log2_r <= fbm_pkg::LOG2_RESET;
      x_edges_r     <= '0;
      y_edges_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fbm_pkg::REG_FILTER_MODE: filter_mode_r <= cfg_wdata[2:0];
        fbm_pkg::REG_VIEW_MODE:   view_mode_r   <= cfg_wdata[1:0];
        fbm_pkg::REG_STOP_GAIN:   stop_gain_r   <= cfg_wdata[fbm_pkg::GAIN_W-1:0];
        fbm_pkg::REG_WIDTH_LOG2:  width_log2_r  <= cfg_wdata[fbm_pkg::LOG2_W-1:0];
        fbm_pkg::REG_HEIGHT_LOG2: height_log2_r <= cfg_wdata[fbm_pkg::LOG2_W-1:0];
        fbm_pkg::REG_X_EDGES:     x_edges_r     <= cfg_wdata[EDGE_W-1:0];
        fbm_pkg::REG_Y_EDGES:     y_edges_r     <= cfg_wdata[EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  logic                  s1_valid, s1_ready, s2_valid, s2_ready, s3_ready;
  logic signed [S-1:0]   s1_re, s1_im, s2_re, s2_im, s3_re, s3_im;
  logic signed [PW-1:0]  s2_rp, s2_ip;
  fbm_pkg::ctl_t         s1_ctl, s2_ctl;
  logic                  s3_pass;

  fbm_region #(.COORD_BITS(COORD_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_region (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_tvalid),
    .up_ready    (in_tready),
    .column      (in_tdata[C-1:0]),
    .row         (in_tdata[2*C-1:C]),
    .re_in       (in_tdata[2*C+S-1:2*C]),
    .im_in       (in_tdata[2*C+2*S-1:2*C+S]),
    .filter_mode (filter_mode_r),
    .view_mode   (view_mode_r),
    .width_log2  (width_log2_r),
    .height_log2 (height_log2_r),
    .x_edges     (x_edges_r),
    .y_edges     (y_edges_r),
    .dn_valid    (s1_valid),
    .dn_ready    (s1_ready),
    .re_out      (s1_re),
    .im_out      (s1_im),
    .ctl_out     (s1_ctl)
  );

  fbm_mult #(.SAMPLE_BITS(SAMPLE_BITS)) u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s1_valid),
    .up_ready  (s1_ready),
    .re_in     (s1_re),
    .im_in     (s1_im),
    .ctl_in    (s1_ctl),
    .stop_gain (stop_gain_r),
    .dn_valid  (s2_valid),
    .dn_ready  (s2_ready),
    .re_out    (s2_re),
    .im_out    (s2_im),
    .re_prod   (s2_rp),
    .im_prod   (s2_ip),
    .ctl_out   (s2_ctl)
  );

  fbm_round #(.SAMPLE_BITS(SAMPLE_BITS)) u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .re_in    (s2_re),
    .im_in    (s2_im),
    .re_prod  (s2_rp),
    .im_prod  (s2_ip),
    .ctl_in   (s2_ctl),
    .dn_valid (out_tvalid),
    .dn_ready (s3_ready),
    .re_out   (s3_re),
    .im_out   (s3_im),
    .passed   (s3_pass)
  );

  assign s3_ready  = out_tready;
  assign out_tdata = OUT_W'({s3_im, s3_re});
  assign out_tuser = s3_pass;

  // a taken output frees the whole pipe for a new transfer
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready) else $error("in_tready low while output drains");

  a_pass_no_scale: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && s1_ctl.pass |-> !s1_ctl.scl_re && !s1_ctl.scl_im)
    else $error("passed bin marked for scaling");

  a_real_copy: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid && s2_ready && !s2_ctl.scl_re |=> out_tdata[S-1:0] == $past(s2_re))
    else $error("unscaled real part altered");

  a_imag_copy: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid && s2_ready && !s2_ctl.scl_im |=> out_tdata[2*S-1:S] == $past(s2_im))
    else $error("unscaled imaginary part altered");

endmodule

// File: dv/tb_frequency_box_mask_filter_top.sv
// ----------------------------------------------------------------------------
// tb_frequency_box_mask_filter_top: testbench for the box mask filter
// Directed checks of box edges, modes, views, gain extremes and grid clamping,
// then random phases under random config, with random gaps on both streams
// and one long output hold-off. Every output bin is checked against a local
// predictor of the shift, box test and Q1.14 scaling.
// ----------------------------------------------------------------------------
module tb_frequency_box_mask_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS   = 12;
  localparam int SAMPLE_BITS  = 32;
  localparam int IN_W         = 88;
  localparam int OUT_W        = 64;
  localparam int CFG_W        = 48;
  localparam int LATENCY      = 3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 140;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               passed;
  } bin_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_W-1:0]   out_tdata;
  logic [0:0]         out_tuser;
  logic               cfg_wr_en;
  logic [fbm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;

  // shadow copy of the block's registers
  logic [2:0]         cur_filter_mode;
  logic [1:0]         cur_view_mode;
  logic signed [14:0] cur_stop_gain;
  logic [3:0]         cur_width_log2;
  logic [3:0]         cur_height_log2;
  logic [47:0]        cur_x_edges;
  logic [47:0]        cur_y_edges;

  bin_result_t expected_bins[$];
  int          mismatches;
  int          bins_checked;
  int          cycle_count;
  int          hold_cycles;   // long receiver hold-off, counted by the receiver
  bit          idle_enable;

  frequency_box_mask_filter_top #(
    .COORD_BITS (COORD_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bins outstanding", cycle_count,
               expected_bins.size());
      $display("[frequency_box_mask_filter_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic int clamp_log2(logic [3:0] v);
    if (v < 4'd1) return 1;
    if (v > 4'd12) return 12;
    return int'(v);
  endfunction

  function automatic logic [11:0] fft_shift(logic [11:0] c, int lg);
    logic [12:0] size;
    size = 13'd1 << lg;
    return 12'((c + (size >> 1)) & (size - 13'd1));
  endfunction

  function automatic logic in_span(logic [11:0] c, logic [11:0] lo, logic [11:0] hi);
    return (c > lo) && (c <= hi);
  endfunction

  function automatic logic signed [31:0] apply_stop_gain(logic signed [31:0] v);
    logic signed [63:0] p;
    p = $signed(v) * $signed(cur_stop_gain);
    p = (p + 64'sd8192) >>> 14;
    if (p > 64'sd2147483647) return 32'h7fff_ffff;
    if (p < -64'sd2147483648) return 32'h8000_0000;
    return p[31:0];
  endfunction

  function automatic bin_result_t filter_bin(logic [11:0] col, logic [11:0] row,
                                             logic signed [31:0] re,
                                             logic signed [31:0] im);
    bin_result_t r;
    logic [11:0] xs;
    logic [11:0] ys;
    logic        inner;
    logic        outer;
    logic        pass;
    xs = fft_shift(col, clamp_log2(cur_width_log2));
    ys = fft_shift(row, clamp_log2(cur_height_log2));
    inner = in_span(xs, cur_x_edges[11:0], cur_x_edges[23:12]) &&
            in_span(ys, cur_y_edges[11:0], cur_y_edges[23:12]);
    outer = in_span(xs, cur_x_edges[35:24], cur_x_edges[47:36]) &&
            in_span(ys, cur_y_edges[35:24], cur_y_edges[47:36]);
    case (cur_filter_mode)
      fbm_pkg::MODE_BOX:      pass = inner;
      fbm_pkg::MODE_BOX_INV:  pass = !inner;
      fbm_pkg::MODE_BAND:     pass = outer && !inner;
      fbm_pkg::MODE_BAND_INV: pass = !outer || inner;
      default:                pass = 1'b1;
    endcase
    r.re = re;
    r.im = im;
    if (!pass) begin
      if (cur_view_mode != fbm_pkg::VIEW_IMAG) r.re = apply_stop_gain(re);
      if (cur_view_mode != fbm_pkg::VIEW_REAL) r.im = apply_stop_gain(im);
    end
    r.passed = pass;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at cycle %0d, result %0d: %s got %h, expected %h",
               cycle_count, bins_checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    bin_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bins.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata[31:0], 32'h0);
      end else begin
        want = expected_bins.pop_front();
        if (out_tdata[31:0] !== want.re)
          report_mismatch("real_out", out_tdata[31:0], want.re);
        if (out_tdata[63:32] !== want.im)
          report_mismatch("imag_out", out_tdata[63:32], want.im);
        if (out_tuser[0] !== want.passed)
          report_mismatch("passed", {31'b0, out_tuser[0]}, {31'b0, want.passed});
      end
      bins_checked++;
    end
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if (idle_enable) begin
          r = $urandom_range(0, 99);
          if (r < 15) stall_left = $urandom_range(1, 3);
          else if (r < 18) stall_left = $urandom_range(8, 30);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sender
  function automatic int pick_gap();
    int r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // called at a falling edge; returns at a falling edge with in_tvalid low
  task automatic send_bin(logic [11:0] col, logic [11:0] row,
                          logic signed [31:0] re, logic signed [31:0] im);
    in_tdata  = {im, re, row, col};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_bins.push_back(filter_bin(col, row, re, im));
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (pick_gap()) @(negedge clk);
  endtask

  task automatic write_reg(logic [fbm_pkg::CFG_IDX_W-1:0] idx, logic [47:0] val);
    cfg_index = idx;
    cfg_wdata = val;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      fbm_pkg::REG_FILTER_MODE: cur_filter_mode = val[2:0];
      fbm_pkg::REG_VIEW_MODE:   cur_view_mode   = val[1:0];
      fbm_pkg::REG_STOP_GAIN:   cur_stop_gain   = val[14:0];
      fbm_pkg::REG_WIDTH_LOG2:  cur_width_log2  = val[3:0];
      fbm_pkg::REG_HEIGHT_LOG2: cur_height_log2 = val[3:0];
      fbm_pkg::REG_X_EDGES:     cur_x_edges     = val;
      fbm_pkg::REG_Y_EDGES:     cur_y_edges     = val;
      default: ;
    endcase
  endtask

  task automatic drain_pipe();
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  function automatic logic [47:0] pack_edges(int il, int ih, int ol, int oh);
    return {12'(oh), 12'(ol), 12'(ih), 12'(il)};
  endfunction

  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [11:0] random_coord(int lg);
    if ($urandom_range(0, 7) == 0) return 12'($urandom);
    return 12'($urandom_range(0, (1 << lg) - 1));
  endfunction

  function automatic int random_edge(int size);
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 4095);
    return $urandom_range(0, size);
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_reset_values();
    // no writes yet: mode none passes everything unchanged
    send_bin(12'd0, 12'd0, 32'sh8000_0000, 32'sh7fff_ffff);
    send_bin(12'hfff, 12'hfff, 32'sh7fff_ffff, 32'sh8000_0000);
    send_bin(12'd128, 12'd77, -32'sd1, 32'sd0);
    drain_pipe();
  endtask

  task automatic test_box_edges();
    // 8x8 grid, shifted coord = (c + 4) & 7; inner box 2 < xs <= 5
    write_reg(fbm_pkg::REG_WIDTH_LOG2, 48'd3);
    write_reg(fbm_pkg::REG_HEIGHT_LOG2, 48'd3);
    write_reg(fbm_pkg::REG_X_EDGES, pack_edges(2, 5, 0, 7));
    write_reg(fbm_pkg::REG_Y_EDGES, pack_edges(2, 5, 0, 7));
    write_reg(fbm_pkg::REG_FILTER_MODE, 48'(fbm_pkg::MODE_BOX));
    write_reg(fbm_pkg::REG_VIEW_MODE, 48'(fbm_pkg::VIEW_BOTH));
    write_reg(fbm_pkg::REG_STOP_GAIN, 48'h4000);          // -1.0, most negative gain
    send_bin(12'd6, 12'd0, 32'sh8000_0000, 32'sh7fff_ffff); // xs=2: low edge excluded
    send_bin(12'd7, 12'd0, 32'sd1000, -32'sd1000);          // xs=3: inside
    send_bin(12'd1, 12'd0, 32'sd5, 32'sd6);                 // xs=5: high edge included
    send_bin(12'd2, 12'd0, 32'sh8000_0000, -32'sd3);        // xs=6: outside, saturates
    send_bin(12'hfff, 12'd0, 32'sd9, 32'sd9);               // beyond grid, wraps to xs=3
    drain_pipe();
    write_reg(fbm_pkg::REG_STOP_GAIN, 48'd8192);          // +0.5, rounding ties upward
    send_bin(12'd2, 12'd0, -32'sd3, 32'sd3);
    send_bin(12'd2, 12'd0, 32'sh7fff_ffff, 32'sh8000_0000);
    drain_pipe();
  endtask

  task automatic test_modes_and_views();
    write_reg(fbm_pkg::REG_STOP_GAIN, 48'h6000);          // -0.5
    write_reg(fbm_pkg::REG_X_EDGES, pack_edges(2, 4, 1, 6));
    for (int m = 0; m < 8; m++) begin
      write_reg(fbm_pkg::REG_FILTER_MODE, 48'(m));
      send_bin(12'd0, 12'd0, 32'sd12345, -32'sd777); // inner box
      if (m >= 1 && m <= 4)
        send_bin(12'd2, 12'd0, 32'sd12345, -32'sd777); // band only
      drain_pipe();
    end
    write_reg(fbm_pkg::REG_FILTER_MODE, 48'(fbm_pkg::MODE_BOX));
    for (int v = 0; v < 4; v++) begin
      write_reg(fbm_pkg::REG_VIEW_MODE, 48'(v));
      send_bin(12'd3, 12'd0, -32'sd4001, 32'sd4001);
      drain_pipe();
    end
  endtask

  task automatic test_grid_clamp();
    // log2 0 acts as 1, log2 15 acts as 12
    write_reg(fbm_pkg::REG_VIEW_MODE, 48'(fbm_pkg::VIEW_BOTH));
    write_reg(fbm_pkg::REG_WIDTH_LOG2, 48'd0);
    write_reg(fbm_pkg::REG_HEIGHT_LOG2, 48'd15);
    write_reg(fbm_pkg::REG_X_EDGES, pack_edges(0, 1, 0, 1));
    write_reg(fbm_pkg::REG_Y_EDGES, pack_edges(2047, 4095, 0, 4095));
    send_bin(12'd0, 12'd0, 32'sd100, 32'sd200);
    send_bin(12'd1, 12'd2047, 32'sd100, 32'sd200);
    drain_pipe();
  endtask

  task automatic randomize_config(bit wild);
    int wl;
    int hl;
    int sx;
    int sy;
    if (wild) begin
      write_reg(fbm_pkg::REG_FILTER_MODE, 48'($urandom_range(0, 7)));
      write_reg(fbm_pkg::REG_VIEW_MODE, 48'($urandom_range(0, 3)));
      write_reg(fbm_pkg::REG_STOP_GAIN, 48'({$urandom, $urandom}));
      write_reg(fbm_pkg::REG_WIDTH_LOG2, 48'($urandom_range(0, 15)));
      write_reg(fbm_pkg::REG_HEIGHT_LOG2, 48'($urandom_range(0, 15)));
      write_reg(fbm_pkg::REG_X_EDGES, 48'({$urandom, $urandom}));
      write_reg(fbm_pkg::REG_Y_EDGES, 48'({$urandom, $urandom}));
    end else begin
      wl = $urandom_range(1, 12);
      hl = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) wl = $urandom_range(1, 5);
      if ($urandom_range(0, 3) != 0) hl = $urandom_range(1, 5);
      sx = 1 << wl;
      sy = 1 << hl;
      write_reg(fbm_pkg::REG_FILTER_MODE, 48'($urandom_range(1, 4)));
      write_reg(fbm_pkg::REG_VIEW_MODE, 48'($urandom_range(0, 2)));
      write_reg(fbm_pkg::REG_STOP_GAIN, 48'($urandom_range(0, 24576) - 16384));
      write_reg(fbm_pkg::REG_WIDTH_LOG2, 48'(wl));
      write_reg(fbm_pkg::REG_HEIGHT_LOG2, 48'(hl));
      // inner box nested in the outer one, now and then empty or odd
      write_reg(fbm_pkg::REG_X_EDGES, pack_edges(random_edge(sx) / 2 + sx / 8,
                                        sx / 2 + random_edge(sx) / 4, random_edge(sx) / 4,
                                        sx - random_edge(sx) / 4));
      write_reg(fbm_pkg::REG_Y_EDGES, pack_edges(random_edge(sy) / 2 + sy / 8,
                                        sy / 2 + random_edge(sy) / 4, random_edge(sy) / 4,
                                        sy - random_edge(sy) / 4));
    end
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_enable = (ph != 3);
      randomize_config(ph == 5 || ph == 6);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_bin(random_coord(clamp_log2(cur_width_log2)),
                 random_coord(clamp_log2(cur_height_log2)),
                 random_sample(), random_sample());
      drain_pipe();
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_backpressure();
    // receiver stops for a long stretch; the pipe fills and in_tready drops
    randomize_config(1'b0);
    idle_enable = 1'b0;
    hold_cycles = 120;
    for (int i = 0; i < 24; i++)
      send_bin(random_coord(clamp_log2(cur_width_log2)),
               random_coord(clamp_log2(cur_height_log2)),
               random_sample(), random_sample());
    idle_enable = 1'b1;
    drain_pipe();
  endtask

  initial begin
    int waited;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    mismatches  = 0;
    bins_checked = 0;
    cycle_count = 0;
    hold_cycles = 0;
    idle_enable = 1'b1;
    cur_filter_mode = fbm_pkg::MODE_NONE;
    cur_view_mode   = fbm_pkg::VIEW_BOTH;
    cur_stop_gain   = '0;
    cur_width_log2  = fbm_pkg::LOG2_RESET;
    cur_height_log2 = fbm_pkg::LOG2_RESET;
    cur_x_edges     = '0;
    cur_y_edges     = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_values();
    test_box_edges();
    test_modes_and_views();
    test_grid_clamp();
    test_random_phases();
    test_backpressure();

    waited = 0;
    while (expected_bins.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (expected_bins.size() != 0) begin
      $display("%0d expected bins never came out", expected_bins.size());
      mismatches += expected_bins.size();
    end

    $display("checked %0d filtered bins: box edges, all modes and views, gain extremes,",
             bins_checked);
    $display("grid clamping, %0d random config phases and a long output hold-off",
             RAND_PHASES);
    if (mismatches == 0) begin
      $display("[frequency_box_mask_filter_top] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[frequency_box_mask_filter_top] ERROR");
    end
    $finish;
  end

endmodule
